@@ design/psm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package psm_pkg;
    localparam int SAMPLES_DEF  = 64;
    localparam int SEGMENTS_DEF = 16;
    localparam logic [1:0] OP_LOAD_EXP = 2'd0;
    localparam logic [1:0] OP_LOAD_LN  = 2'd1;
    localparam logic [1:0] OP_SAMPLE   = 2'd2;
    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam logic [1:0] REG_EXP_USED = 2'd0;
    localparam logic [1:0] REG_LN_USED  = 2'd1;
    localparam logic [1:0] REG_CUTOFF   = 2'd2;
    localparam logic [23:0] SUM_MAX = 24'hFFFFFF;
    localparam logic [17:0] TWO_Q16 = 18'd131072;
    localparam logic [15:0] LN2_Q16 = 16'd45426;

    typedef struct packed {
        logic signed [15:0] lo;
        logic signed [15:0] hi;
        logic signed [15:0] k;
        logic signed [15:0] b;
    } seg_t;
endpackage
`default_nettype wire

@@ design/pwl_softmax.sv @@
`timescale 1ns / 1ps
`default_nettype none
// A non-last sample or a table load is accepted and the block stays idle and ready.
// A last sample starts the computation; input is not ready until the last result is registered.
// Each lookup reads the store (FETCH, RD), then tries segments in order (SRCH, OUT); an exp
// lookup below cutoff skips that. Order: N exp, HALV, one ln, N exp; out stalls hold MUL.
// Reset clears control state and counters and sets max and config defaults; tables and store stay undefined.
module pwl_softmax
    import psm_pkg::*;
#(
    parameter int SAMPLES  = SAMPLES_DEF,
    parameter int SEGMENTS = SEGMENTS_DEF
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  op,
    input  wire logic [3:0]  seg_index,
    input  wire logic signed [15:0] seg_low,
    input  wire logic signed [15:0] seg_high,
    input  wire logic signed [15:0] seg_slope,
    input  wire logic signed [15:0] seg_intercept,
    input  wire logic signed [15:0] sample_value,
    input  wire logic        last,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      probability,
    output logic [5:0]       result_index,
    output logic             no_segment,
    output logic             last_result,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    localparam int SW = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int GW = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
    localparam int CW = $clog2(SAMPLES + 1);
    localparam int NW = $clog2(SEGMENTS + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RD    = 3'd1;
    localparam logic [2:0] ST_SRCH  = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_HALV  = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;
    localparam logic [2:0] ST_FETCH = 3'd6;

    localparam logic [1:0] PH_SUM = 2'd0;
    localparam logic [1:0] PH_LN  = 2'd1;
    localparam logic [1:0] PH_EMT = 2'd2;

    logic signed [15:0] store_mem [SAMPLES];
    seg_t exp_mem [SEGMENTS];
    seg_t ln_mem [SEGMENTS];

    logic [2:0]  state_reg;
    logic [1:0]  phase_reg;
    logic [CW-1:0] count_reg;
    logic [SW-1:0] idx_reg;
    logic [NW-1:0] seg_reg;
    logic signed [15:0] max_reg;
    logic [4:0]  exp_used_reg, ln_used_reg;
    logic signed [15:0] cutoff_reg;
    logic [23:0] sum_reg;
    logic [4:0]  halv_reg;
    logic signed [40:0] common_reg;
    logic signed [40:0] arg_reg;
    logic        gmiss_reg;
    logic        miss_reg;
    logic signed [15:0] samp_reg;
    seg_t        seg_q_reg;
    logic signed [40:0] val_reg;
    logic        out_valid_reg;
    logic [15:0] prob_reg;
    logic [5:0]  ridx_reg;
    logic        nseg_reg;
    logic        lres_reg;

    logic in_fire, out_fire;
    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;
    assign out_valid = out_valid_reg;
    assign probability = prob_reg;
    assign result_index = ridx_reg;
    assign no_segment = nseg_reg;
    assign last_result = lres_reg;

    logic [4:0] used_w;
    logic [NW-1:0] lim_w;
    logic signed [40:0] lo_w, hi_w, prod_w;
    logic hit_w, done_w, below_w;
    always_comb
    begin
        used_w = (phase_reg == PH_LN) ? ln_used_reg : exp_used_reg;
        if (32'(used_w) > SEGMENTS)
            lim_w = NW'(SEGMENTS);
        else
            lim_w = NW'(used_w);
        lo_w = 41'(seg_q_reg.lo) <<< 8;
        hi_w = 41'(seg_q_reg.hi) <<< 8;
        hit_w = (arg_reg >= lo_w) && (arg_reg <= hi_w);
        done_w = (32'(seg_reg) + 1 >= 32'(lim_w));
        below_w = (phase_reg != PH_LN) && (arg_reg < (41'(cutoff_reg) <<< 8));
        prod_w = 41'(arg_reg * 41'(seg_q_reg.k)) >>> 14;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && (op == OP_LOAD_EXP) && (32'(seg_index) < SEGMENTS))
            exp_mem[GW'(seg_index)] <= '{seg_low, seg_high, seg_slope, seg_intercept};
        if (in_fire && (op == OP_LOAD_LN) && (32'(seg_index) < SEGMENTS))
            ln_mem[GW'(seg_index)] <= '{seg_low, seg_high, seg_slope, seg_intercept};
        if (in_fire && (op == OP_SAMPLE) && (32'(count_reg) < SAMPLES))
            store_mem[SW'(count_reg)] <= sample_value;
        samp_reg <= store_mem[idx_reg];
        if (phase_reg == PH_LN)
            seg_q_reg <= ln_mem[GW'(seg_reg)];
        else
            seg_q_reg <= exp_mem[GW'(seg_reg)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_SUM;
            count_reg <= '0;
            idx_reg <= '0;
            seg_reg <= '0;
            max_reg <= 16'sh8000;
            exp_used_reg <= 5'd16;
            ln_used_reg <= 5'd16;
            cutoff_reg <= -16'sd2048;
            sum_reg <= '0;
            halv_reg <= '0;
            common_reg <= '0;
            arg_reg <= '0;
            gmiss_reg <= 1'b0;
            miss_reg <= 1'b0;
            val_reg <= '0;
            out_valid_reg <= 1'b0;
            prob_reg <= '0;
            ridx_reg <= '0;
            nseg_reg <= 1'b0;
            lres_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_EXP_USED: exp_used_reg <= cfg_data[4:0];
                    REG_LN_USED:  ln_used_reg <= cfg_data[4:0];
                    REG_CUTOFF:   cutoff_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (out_fire)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire && op == OP_SAMPLE)
                    begin
                        if (32'(count_reg) < SAMPLES)
                        begin
                            count_reg <= count_reg + 1'b1;
                            if (sample_value > max_reg)
                                max_reg <= sample_value;
                        end
                        if (last)
                        begin
                            idx_reg <= '0;
                            seg_reg <= '0;
                            sum_reg <= '0;
                            halv_reg <= '0;
                            gmiss_reg <= 1'b0;
                            phase_reg <= PH_SUM;
                            if (count_reg == '0 && !(32'(count_reg) < SAMPLES))
                                state_reg <= ST_IDLE;
                            else if (count_reg == '0 && !(SAMPLES > 0))
                                state_reg <= ST_IDLE;
                            else
                                state_reg <= ST_FETCH;
                        end
                    end
                end
                ST_FETCH:
                begin
                    // wait for the store read at the new index
                    state_reg <= ST_RD;
                end
                ST_RD:
                begin
                    seg_reg <= '0;
                    state_reg <= ST_SRCH;
                    if (phase_reg == PH_LN)
                        arg_reg <= 41'(sum_reg);
                    else if (phase_reg == PH_SUM)
                        arg_reg <= (41'(samp_reg) - 41'(max_reg)) <<< 8;
                    else
                        arg_reg <= ((41'(samp_reg) - 41'(max_reg)) <<< 8) - common_reg;
                end
                ST_SRCH:
                begin
                    if (below_w)
                    begin
                        val_reg <= '0;
                        miss_reg <= 1'b0;
                        state_reg <= ST_MUL;
                    end
                    else if (lim_w == '0)
                    begin
                        val_reg <= '0;
                        miss_reg <= 1'b1;
                        state_reg <= ST_MUL;
                    end
                    else
                    begin
                        // go to ST_OUT while the table read settles
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    // seg_q_reg now holds entry seg_reg
                    if (hit_w)
                    begin
                        val_reg <= prod_w + (41'(seg_q_reg.b) <<< 2);
                        miss_reg <= 1'b0;
                        state_reg <= ST_MUL;
                    end
                    else if (done_w)
                    begin
                        val_reg <= '0;
                        miss_reg <= 1'b1;
                        state_reg <= ST_MUL;
                    end
                    else
                    begin
                        seg_reg <= seg_reg + 1'b1;
                        state_reg <= ST_SRCH;
                    end
                end
                ST_MUL:
                begin
                    case (phase_reg)
                        PH_SUM:
                        begin
                            logic [24:0] s;
                            s = 25'(sum_reg);
                            if (miss_reg) gmiss_reg <= 1'b1;
                            if (val_reg > $signed(41'(SUM_MAX)))
                                s = s + 25'(SUM_MAX);
                            else if (val_reg > 0)
                                s = s + 25'(val_reg);
                            sum_reg <= (s > 25'(SUM_MAX)) ? SUM_MAX : s[23:0];
                            if (32'(idx_reg) + 1 >= 32'(count_reg))
                            begin
                                state_reg <= ST_HALV;
                                idx_reg <= '0;
                            end
                            else
                            begin
                                idx_reg <= idx_reg + 1'b1;
                                state_reg <= ST_FETCH;
                            end
                        end
                        PH_LN:
                        begin
                            if (miss_reg) gmiss_reg <= 1'b1;
                            common_reg <= val_reg + 41'(halv_reg) * 41'(LN2_Q16);
                            phase_reg <= PH_EMT;
                            idx_reg <= '0;
                            state_reg <= ST_FETCH;
                        end
                        default:
                        begin
                            if (!out_valid_reg)
                            begin
                                out_valid_reg <= 1'b1;
                                if (val_reg < 0)
                                    prob_reg <= '0;
                                else if ((val_reg >>> 1) > 41'sd32768)
                                    prob_reg <= 16'd32768;
                                else
                                    prob_reg <= 16'(val_reg >>> 1);
                                ridx_reg <= 6'(idx_reg);
                                nseg_reg <= miss_reg | gmiss_reg;
                                lres_reg <= (32'(idx_reg) + 1 >= 32'(count_reg));
                                if (32'(idx_reg) + 1 >= 32'(count_reg))
                                begin
                                    state_reg <= ST_IDLE;
                                    count_reg <= '0;
                                    max_reg <= 16'sh8000;
                                    phase_reg <= PH_SUM;
                                end
                                else
                                begin
                                    idx_reg <= idx_reg + 1'b1;
                                    state_reg <= ST_FETCH;
                                end
                            end
                        end
                    endcase
                end
                ST_HALV:
                begin
                    if (sum_reg >= 24'(TWO_Q16))
                    begin
                        sum_reg <= sum_reg >> 1;
                        halv_reg <= halv_reg + 1'b1;
                    end
                    else
                    begin
                        phase_reg <= PH_LN;
                        state_reg <= ST_FETCH;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 1ps
module tb;
    import psm_pkg::*;

    typedef struct packed {
        logic [15:0] prob;
        logic [5:0]  idx;
        logic        miss;
        logic        lastr;
    } prob_beat_t;

    class softmax_scoreboard;
        seg_t exp_tab[16];
        seg_t ln_tab[16];
        int exp_used = 16;
        int ln_used = 16;
        logic signed [15:0] cutoff = -16'sd2048;
        logic signed [15:0] samples[64];
        int fill = 0;
        int vmax = -32768;
        prob_beat_t awaited[$];
        int errors = 0;
        int results = 0;
        int vectors = 0;

        function void write_reg(logic [1:0] idx, logic [15:0] d);
            if (idx == REG_EXP_USED) exp_used = int'(d[4:0]);
            else if (idx == REG_LN_USED) ln_used = int'(d[4:0]);
            else if (idx == REG_CUTOFF) cutoff = d;
        endfunction

        function longint seg_eval(bit use_ln, longint a, ref bit miss);
            seg_t s;
            int n;
            n = use_ln ? ln_used : exp_used;
            if (n > 16) n = 16;
            for (int i = 0; i < n; i++) begin
                s = use_ln ? ln_tab[i] : exp_tab[i];
                if (a >= longint'(s.lo) * 256 && a <= longint'(s.hi) * 256)
                    return ((a * longint'(s.k)) >>> 14) + longint'(s.b) * 4;
            end
            miss = 1'b1;
            return 0;
        endfunction

        function longint exp_eval(longint a, ref bit miss);
            if (a < longint'(cutoff) * 256) return 0;
            return seg_eval(1'b0, a, miss);
        endfunction

        function void note(logic [1:0] op, logic [3:0] slot, seg_t s,
                           logic signed [15:0] sv, logic lst);
            longint sum, e, common, a, p;
            int halvings;
            bit gmiss, miss;
            prob_beat_t r;
            if (op == OP_LOAD_EXP) exp_tab[slot] = s;
            else if (op == OP_LOAD_LN) ln_tab[slot] = s;
            if (op != OP_SAMPLE) return;
            if (fill < 64) begin
                samples[fill] = sv;
                fill++;
                if (int'(sv) > vmax) vmax = int'(sv);
            end
            if (!lst) return;
            sum = 0;
            halvings = 0;
            gmiss = 1'b0;
            for (int i = 0; i < fill; i++) begin
                e = exp_eval((longint'(samples[i]) - vmax) * 256, gmiss);
                if (e < 0) e = 0;
                if (e > 16777215) e = 16777215;
                sum += e;
                if (sum > 16777215) sum = 16777215;
            end
            while (sum >= 131072) begin
                sum = sum >> 1;
                halvings++;
            end
            common = seg_eval(1'b1, sum, gmiss) + longint'(halvings) * 45426;
            for (int i = 0; i < fill; i++) begin
                miss = gmiss;
                a = (longint'(samples[i]) - vmax) * 256 - common;
                e = exp_eval(a, miss);
                p = (e < 0) ? 0 : (e >>> 1);
                if (p > 32768) p = 32768;
                r.prob = p[15:0];
                r.idx = i[5:0];
                r.miss = miss;
                r.lastr = (i + 1 == fill);
                awaited.insert(awaited.size(), r);
            end
            vectors++;
            fill = 0;
            vmax = -32768;
        endfunction

        function void check(prob_beat_t got);
            prob_beat_t want;
            results++;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result beat %p", $realtime, got);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.prob !== want.prob) begin
                $display("%0t: probability exp %0d act %0d", $realtime, want.prob, got.prob);
                errors++;
            end
            if (got.idx !== want.idx) begin
                $display("%0t: result_index exp %0d act %0d", $realtime, want.idx, got.idx);
                errors++;
            end
            if (got.miss !== want.miss) begin
                $display("%0t: no_segment exp %0d act %0d", $realtime, want.miss, got.miss);
                errors++;
            end
            if (got.lastr !== want.lastr) begin
                $display("%0t: last_result exp %0d act %0d", $realtime, want.lastr, got.lastr);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] op = OP_SAMPLE;
    logic [3:0] seg_index = '0;
    logic signed [15:0] seg_low = '0;
    logic signed [15:0] seg_high = '0;
    logic signed [15:0] seg_slope = '0;
    logic signed [15:0] seg_intercept = '0;
    logic signed [15:0] sample_value = '0;
    logic last = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [15:0] probability;
    logic [5:0] result_index;
    logic no_segment;
    logic last_result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = REG_EXP_USED;
    logic [15:0] cfg_data = '0;

    softmax_scoreboard board = new();
    bit send_idle = 1'b1;
    bit sink_idle = 1'b1;
    bit hold_req = 1'b0;
    int sent = 0;
    int stall_cycles = 0;

    pwl_softmax DUT (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= 20000) begin
            $display("** pwl_softmax: FAILED **");
            $finish;
        end
    end

    initial
    begin
        int gap;
        wait (rst_n);
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ready = 1'b0;
                repeat (3000) @(negedge clk);
            end
            gap = sink_idle ? $urandom_range(0, 8) : 0;
            if (gap > 0) begin
                out_ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready = 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            board.check({probability, result_index, no_segment, last_result});
        end
    end

    task automatic send_beat(logic [1:0] o, logic [3:0] slot, seg_t s,
                             logic signed [15:0] sv, logic lst);
        int gap;
        gap = send_idle ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        op = o;
        seg_index = slot;
        {seg_low, seg_high, seg_slope, seg_intercept} = s;
        sample_value = sv;
        last = lst;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note(o, slot, s, sv, lst);
        sent++;
        @(negedge clk);
    endtask

    task automatic send_sample(logic signed [15:0] sv, logic lst);
        send_beat(OP_SAMPLE, 4'($urandom), seg_t'({$urandom, $urandom}), sv, lst);
    endtask

    task automatic send_vector(int len, int base, int spread);
        int v;
        for (int i = 0; i < len; i++) begin
            v = base + $urandom_range(0, 2 * spread) - spread;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            send_sample(v[15:0], i == len - 1);
        end
    endtask

    function automatic logic signed [15:0] to_q14(real r);
        real q;
        q = r * 16384.0;
        if (q > 32767.0) q = 32767.0;
        if (q < -32768.0) q = -32768.0;
        return 16'($rtoi(q));
    endfunction

    task automatic load_tables();
        real m, e;
        seg_t s;
        for (int i = 0; i < 16; i++) begin
            m = -8.0 + 0.5 * i + 0.25;
            e = $exp(m);
            s.lo = 16'(-2048 + 128 * i);
            s.hi = (i == 15) ? 16'sd32767 : 16'(-2048 + 128 * i + 127);
            s.k = to_q14(e);
            s.b = to_q14(e - m * e);
            send_beat(OP_LOAD_EXP, 4'(i), s, 16'($urandom), 1'($urandom));
        end
        for (int i = 0; i < 16; i++) begin
            m = (i + 0.5) / 8.0;
            s.lo = 16'(32 * i);
            s.hi = (i == 15) ? 16'sd32767 : 16'(32 * i + 31);
            s.k = to_q14(1.0 / m);
            s.b = to_q14($ln(m) - 1.0);
            send_beat(OP_LOAD_LN, 4'(i), s, 16'($urandom), 1'($urandom));
        end
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (board.awaited.size() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [15:0] d);
        cfg_index = idx;
        cfg_data = d;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.write_reg(idx, d);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_regs(int eu, int lu, int cut);
        drain();
        write_cfg(REG_EXP_USED, eu[15:0]);
        write_cfg(REG_LN_USED, lu[15:0]);
        write_cfg(REG_CUTOFF, cut[15:0]);
    endtask

    initial
    begin
        int len;
        int kind;
        bit held;
        held = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        load_tables();
        send_sample(16'sd32767, 1'b0);
        send_sample(-16'sd32768, 1'b0);
        send_sample(16'sd0, 1'b1);
        send_sample(16'sd100, 1'b1);
        send_beat(OP_UNUSED, 4'hF, seg_t'({$urandom, $urandom}), 16'sd5, 1'b1);
        send_vector(5, 0, 400);
        set_regs(0, 16, -2048);
        send_vector(3, 0, 100);
        set_regs(31, 1, 0);
        send_vector(4, 0, 200);
        set_regs(1, 0, -32768);
        send_vector(3, -200, 300);
        set_regs(16, 16, -2048);
        send_vector(66, 0, 600);
        while (sent < 440) begin
            send_idle = $urandom_range(0, 3) != 0;
            sink_idle = $urandom_range(0, 3) != 0;
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                set_regs($urandom_range(0, 31), $urandom_range(0, 31),
                         -$urandom_range(0, 32768));
            end else if (kind == 1) begin
                set_regs($urandom_range(12, 16), 16, -$urandom_range(1024, 4096));
                load_tables();
            end
            for (int j = 0; j < 6; j++) begin
                kind = $urandom_range(0, 19);
                if (kind == 0)
                    send_beat(2'($urandom_range(0, 1)), 4'($urandom),
                              seg_t'({$urandom, $urandom}), 16'($urandom), 1'($urandom));
                else if (kind == 1)
                    send_beat(OP_UNUSED, 4'($urandom), seg_t'({$urandom, $urandom}),
                              16'($urandom), 1'($urandom));
                else if (kind == 2)
                    send_sample(16'($urandom), 1'($urandom));
                else begin
                    len = (kind == 3) ? $urandom_range(60, 70) : $urandom_range(1, 8);
                    send_vector(len, $urandom_range(0, 65535) - 32768,
                                $urandom_range(0, 3) == 0 ? 32767 : $urandom_range(0, 1500));
                end
            end
            if (!held && sent > 200) begin
                held = 1'b1;
                drain();
                hold_req = 1'b1;
                send_vector(64, 0, 800);
                send_vector(20, 0, 300);
            end
        end
        drain();
        repeat (200) @(negedge clk);
        $display("Ran %0d input beats, %0d vectors, %0d probability beats checked",
                 sent, board.vectors, board.results);
        $display("Covered config extremes, table misses, cutoff edges and full-store drops");
        if (board.errors == 0 && board.awaited.size() == 0)
            $display("** pwl_softmax: PASSED **");
        else
            $display("** pwl_softmax: FAILED **");
        $finish;
    end
endmodule
